// ===== hdl/ulac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulac_pkg: shared types and constants of the line character decoder
// Word formats of both channels, the queue entry passed from the front
// sequencer to the result stage, byte codes and small helper functions.
// ----------------------------------------------------------------------------
package ulac_pkg;

  localparam int ULAC_LINE_CHARS  = 256;
  localparam int ULAC_QUEUE_DEPTH = 4;

  localparam int POS_W  = 9;
  localparam int CODE_W = 16;
  localparam int ATTR_W = 5;
  localparam int TAB_W  = 5;
  localparam int REP_W  = 4;
  localparam int PH_W   = 4;

  localparam logic [TAB_W-1:0] TAB_RESET = 5'd8;
  localparam logic [TAB_W-1:0] TAB_MAX   = 5'd16;

  localparam logic [7:0] B_BS        = 8'h08;
  localparam logic [7:0] B_TAB       = 8'h09;
  localparam logic [7:0] B_CR        = 8'h0D;
  localparam logic [7:0] B_CTRL_TOP  = 8'h20;
  localparam logic [7:0] B_ATTR_LEAD = 8'hCA;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CTRL_OFFSET = 8'h40;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  position;
    logic [CODE_W-1:0] code_point;
    logic [ATTR_W-1:0] attribute;
    logic              special_mark;
    logic              bold;
    logic              bad_byte;
    logic              last;
  } out_item_t;

  // One queue entry: a result word plus the number of plain spaces that
  // follow it at the next positions.
  typedef struct packed {
    out_item_t         item;
    logic [REP_W-1:0]  rep;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_rd_t;

  function automatic logic [CODE_W-1:0] bad_code(input logic [7:0] b);
    logic [CODE_W-1:0] v;
    v = CODE_W'(b);
    if (b[6]) begin
      return v + 16'h0350;
    end
    return v + 16'h0060;
  endfunction

  function automatic logic [TAB_W-1:0] eff_tab(input logic [TAB_W-1:0] tw);
    if (tw == '0) begin
      return 5'd1;
    end
    if (tw > TAB_MAX) begin
      return TAB_MAX;
    end
    return tw;
  endfunction

endpackage

// ===== hdl/ulac_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulac_fifo: operation queue
// Short first-in first-out queue that decouples the front sequencer from
// the result stage.
// ----------------------------------------------------------------------------
module ulac_fifo import ulac_pkg::*; #(
  parameter int DEPTH = ULAC_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  input  logic  q_pop,
  output q_rd_t q_rd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] wp_nxt;
  logic [AW-1:0] rp_nxt;
  logic [CW-1:0] cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_full     = (cnt_r == CW'(DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.op    = mem_r[rp_r];
  assign do_push    = q_wr.valid && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= q_wr.op;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/ulac_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulac_front: byte classifier and line state sequencer
// Accepts bytes, decodes UTF-8, markers, control bytes and backspaces,
// tracks the line position and tab phase, and queues result operations.
// ----------------------------------------------------------------------------
module ulac_front import ulac_pkg::*; #(
  parameter int LINE_CHARS = ULAC_LINE_CHARS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [TAB_W-1:0] cfg_wdata,
  output q_wr_t            q_wr,
  input  logic             q_full
);

  localparam int PW = $clog2(LINE_CHARS + 1);
  localparam int KW = $clog2(PW);
  localparam int SW = PW + TAB_W;
  localparam logic [PW-1:0] LIM = PW'(LINE_CHARS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_BS, ST_HELD, ST_BAD1, ST_START,
    ST_FIN, ST_FB0, ST_FB1, ST_FEND, ST_FLUSH
  } state_t;

  state_t            st_r, st_nxt;
  logic [7:0]        b_r, b_nxt;
  logic              e_r, e_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PH_W-1:0]   ph_r, ph_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic [7:0]        held0_r, held0_nxt;
  logic [7:0]        held1_r, held1_nxt;
  logic [1:0]        hcnt_r, hcnt_nxt;
  logic              bsp_r, bsp_nxt;
  logic              stg_v_r, stg_v_nxt;
  op_t               stg_r, stg_nxt;
  logic [TAB_W-1:0]  tw_r, tw_nxt;
  logic              rc_busy_r, rc_busy_nxt;
  logic [PW-1:0]     rc_rem_r, rc_rem_nxt;
  logic [KW-1:0]     rc_k_r, rc_k_nxt;

  logic [TAB_W-1:0]  twe;
  logic              hold;
  logic              gen;
  op_t               gop;
  logic              put_en;
  logic [CODE_W-1:0] p_code;
  logic              p_spc;
  logic              p_bad;
  logic              dec_en;
  logic              push;
  op_t               push_op;
  logic [SW-1:0]     rc_sh;
  logic              rc_ge;
  logic [PW-1:0]     rc_diff;
  logic [TAB_W-1:0]  ph5;
  logic [PH_W-1:0]   ph_inc;
  logic [PH_W-1:0]   ph_dec;
  logic [TAB_W-1:0]  extras;
  logic [PW-1:0]     room;
  logic [REP_W-1:0]  rep;
  logic [TAB_W-1:0]  tab_ph;
  logic              b_cont;
  logic              b_lead;
  logic              b_print;
  logic              h0_cont;

  assign in_stall = (st_r != ST_IDLE) || rc_busy_r;
  assign q_wr.valid = push;
  assign q_wr.op    = push_op;

  always_comb begin
    twe     = eff_tab(tw_r);
    hold    = (st_r != ST_IDLE) && stg_v_r && q_full;
    b_cont  = (b_r[7:6] == 2'b10);
    b_lead  = (b_r[7:5] == 3'b110) || (b_r[7:4] == 4'b1110);
    b_print = (b_r > CH_SPACE) && (b_r <= CH_TILDE);
    h0_cont = (held0_r[7:5] == 3'b110);

    ph5    = {1'b0, ph_r} + 5'd1;
    ph_inc = (ph5 == twe) ? '0 : ph5[PH_W-1:0];
    ph_dec = (ph_r == '0) ? PH_W'(twe - 5'd1) : ph_r - 1'b1;

    extras = twe - 5'd1 - {1'b0, ph_r};
    room   = LIM - 1'b1 - pos_r;
    rep    = (PW'(extras) > room) ? REP_W'(room) : REP_W'(extras);
    tab_ph = {1'b0, ph_r} + 5'd1 + {1'b0, rep};

    rc_sh   = SW'(twe) << rc_k_r;
    rc_ge   = (SW'(rc_rem_r) >= rc_sh);
    rc_diff = rc_rem_r - PW'(rc_sh);

    st_nxt      = st_r;
    b_nxt       = b_r;
    e_nxt       = e_r;
    pos_nxt     = pos_r;
    ph_nxt      = ph_r;
    attr_nxt    = attr_r;
    held0_nxt   = held0_r;
    held1_nxt   = held1_r;
    hcnt_nxt    = hcnt_r;
    bsp_nxt     = bsp_r;
    stg_v_nxt   = stg_v_r;
    stg_nxt     = stg_r;
    tw_nxt      = tw_r;
    rc_busy_nxt = rc_busy_r;
    rc_rem_nxt  = rc_rem_r;
    rc_k_nxt    = rc_k_r;
    gen         = 1'b0;
    gop         = '0;
    put_en      = 1'b0;
    p_code      = '0;
    p_spc       = 1'b0;
    p_bad       = 1'b0;
    dec_en      = 1'b0;
    push        = 1'b0;
    push_op     = stg_r;

    // Column phase is rebuilt by restoring remainder after a tab width write.
    if (rc_busy_r) begin
      if (rc_ge) begin
        rc_rem_nxt = rc_diff;
      end
      if (rc_k_r == '0) begin
        rc_busy_nxt = 1'b0;
        ph_nxt      = PH_W'(rc_ge ? rc_diff : rc_rem_r);
      end else begin
        rc_k_nxt = rc_k_r - 1'b1;
      end
    end
    if (cfg_we) begin
      tw_nxt      = cfg_wdata;
      rc_busy_nxt = 1'b1;
      rc_rem_nxt  = pos_r;
      rc_k_nxt    = KW'(PW - 1);
    end

    if (!hold) begin
      case (st_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            b_nxt  = in_item.byte_in;
            e_nxt  = in_item.line_end;
            st_nxt = ST_BS;
          end
        end
        ST_BS: begin
          st_nxt = ST_HELD;
          if (bsp_r) begin
            bsp_nxt = 1'b0;
            if (b_print) begin
              gen                   = 1'b1;
              gop.item.kind         = KIND_CHAR;
              gop.item.position     = POS_W'(pos_r - 1'b1);
              gop.item.code_point   = CODE_W'(b_r);
              gop.item.bold         = 1'b1;
              st_nxt                = ST_FIN;
            end else begin
              dec_en = 1'b1;
            end
          end
        end
        ST_HELD: begin
          st_nxt = ST_START;
          if (hcnt_r == 2'd1) begin
            hcnt_nxt = 2'd0;
            if (b_cont) begin
              st_nxt = ST_FIN;
              if (held0_r == B_ATTR_LEAD) begin
                attr_nxt = b_r[ATTR_W-1:0];
              end else if (h0_cont) begin
                put_en = 1'b1;
                p_code = {5'd0, held0_r[4:0], b_r[5:0]};
              end else begin
                held1_nxt = b_r;
                hcnt_nxt  = 2'd2;
              end
            end else begin
              put_en = 1'b1;
              p_code = bad_code(held0_r);
              p_bad  = 1'b1;
            end
          end else if (hcnt_r == 2'd2) begin
            hcnt_nxt = 2'd0;
            put_en   = 1'b1;
            if (b_cont) begin
              p_code = {held0_r[3:0], held1_r[5:0], b_r[5:0]};
              st_nxt = ST_FIN;
            end else begin
              p_code = bad_code(held0_r);
              p_bad  = 1'b1;
              st_nxt = ST_BAD1;
            end
          end
        end
        ST_BAD1: begin
          put_en = 1'b1;
          p_code = bad_code(held1_r);
          p_bad  = 1'b1;
          st_nxt = ST_START;
        end
        ST_START: begin
          st_nxt = ST_FIN;
          if (pos_r < LIM) begin
            if (b_lead) begin
              held0_nxt = b_r;
              hcnt_nxt  = 2'd1;
            end else if (b_r == B_CR) begin
              put_en = 1'b1;
              p_code = CODE_W'(CH_SEMI);
              p_spc  = 1'b1;
            end else if (b_r == B_TAB) begin
              gen                   = 1'b1;
              gop.item.kind         = KIND_CHAR;
              gop.item.position     = POS_W'(pos_r);
              gop.item.code_point   = CODE_W'(CH_SPACE);
              gop.item.attribute    = attr_r;
              gop.item.special_mark = 1'b1;
              gop.rep               = rep;
              pos_nxt               = pos_r + 1'b1 + PW'(rep);
              ph_nxt                = (tab_ph == twe) ? '0 : PH_W'(tab_ph);
            end else if (b_r == B_BS) begin
              if (pos_r != '0) begin
                bsp_nxt = 1'b1;
              end
            end else if (b_r[7]) begin
              put_en = 1'b1;
              p_code = bad_code(b_r);
              p_bad  = 1'b1;
            end else if (b_r < B_CTRL_TOP) begin
              put_en = 1'b1;
              p_code = CODE_W'(b_r + CTRL_OFFSET);
              p_spc  = 1'b1;
            end else begin
              put_en = 1'b1;
              p_code = CODE_W'(b_r);
            end
          end
        end
        ST_FIN: begin
          st_nxt = ST_FLUSH;
          if (e_r) begin
            st_nxt = ST_FB0;
            if (bsp_r) begin
              bsp_nxt = 1'b0;
              dec_en  = 1'b1;
            end
          end
        end
        ST_FB0: begin
          st_nxt = ST_FEND;
          if (hcnt_r != 2'd0) begin
            put_en = 1'b1;
            p_code = bad_code(held0_r);
            p_bad  = 1'b1;
            if (hcnt_r == 2'd2) begin
              st_nxt = ST_FB1;
            end
          end
          hcnt_nxt = 2'd0;
        end
        ST_FB1: begin
          put_en = 1'b1;
          p_code = bad_code(held1_r);
          p_bad  = 1'b1;
          st_nxt = ST_FEND;
        end
        ST_FEND: begin
          gen               = 1'b1;
          gop.item.kind     = KIND_END;
          gop.item.position = POS_W'(pos_r);
          pos_nxt           = '0;
          ph_nxt            = '0;
          attr_nxt          = '0;
          hcnt_nxt          = 2'd0;
          st_nxt            = ST_FLUSH;
        end
        ST_FLUSH: begin
          if (stg_v_r) begin
            push              = 1'b1;
            push_op.item.last = 1'b1;
            stg_v_nxt         = 1'b0;
          end
          st_nxt = ST_IDLE;
        end
        default: begin
          st_nxt = ST_IDLE;
        end
      endcase
    end

    if (put_en && (pos_r < LIM)) begin
      gen                   = 1'b1;
      gop.item.kind         = KIND_CHAR;
      gop.item.position     = POS_W'(pos_r);
      gop.item.code_point   = p_code;
      gop.item.attribute    = attr_r;
      gop.item.special_mark = p_spc;
      gop.item.bad_byte     = p_bad;
      pos_nxt               = pos_r + 1'b1;
      ph_nxt                = ph_inc;
    end
    if (dec_en) begin
      pos_nxt = pos_r - 1'b1;
      ph_nxt  = ph_dec;
    end

    // The newest word waits in the staging register until it is known
    // whether it closes the byte.
    if (gen) begin
      push      = stg_v_r;
      stg_nxt   = gop;
      stg_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      pos_r     <= '0;
      ph_r      <= '0;
      attr_r    <= '0;
      hcnt_r    <= '0;
      bsp_r     <= 1'b0;
      stg_v_r   <= 1'b0;
      tw_r      <= TAB_RESET;
      rc_busy_r <= 1'b0;
      rc_k_r    <= '0;
    end else begin
      st_r      <= st_nxt;
      b_r       <= b_nxt;
      e_r       <= e_nxt;
      pos_r     <= pos_nxt;
      ph_r      <= ph_nxt;
      attr_r    <= attr_nxt;
      held0_r   <= held0_nxt;
      held1_r   <= held1_nxt;
      hcnt_r    <= hcnt_nxt;
      bsp_r     <= bsp_nxt;
      stg_v_r   <= stg_v_nxt;
      stg_r     <= stg_nxt;
      tw_r      <= tw_nxt;
      rc_busy_r <= rc_busy_nxt;
      rc_rem_r  <= rc_rem_nxt;
      rc_k_r    <= rc_k_nxt;
    end
  end

endmodule

// ===== hdl/ulac_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulac_back: result stage
// Takes queued operations, expands tab runs into one space per cycle when
// not stalled, and holds each result word in the output register until taken.
// ----------------------------------------------------------------------------
module ulac_back import ulac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_rd_t     q_rd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic              ov_r, ov_nxt;
  out_item_t         out_r, out_nxt;
  logic [REP_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic              lst_r, lst_nxt;
  logic              load;

  assign out_valid = ov_r;
  assign out_item  = out_r;
  assign load      = !ov_r || !out_stall;

  always_comb begin
    ov_nxt   = ov_r;
    out_nxt  = out_r;
    rem_nxt  = rem_r;
    pos_nxt  = pos_r;
    attr_nxt = attr_r;
    lst_nxt  = lst_r;
    q_pop    = 1'b0;
    if (load) begin
      if (rem_r != '0) begin
        out_nxt            = '0;
        out_nxt.kind       = KIND_CHAR;
        out_nxt.position   = pos_r + 1'b1;
        out_nxt.code_point = CODE_W'(CH_SPACE);
        out_nxt.attribute  = attr_r;
        out_nxt.last       = lst_r && (rem_r == REP_W'(1));
        ov_nxt             = 1'b1;
        rem_nxt            = rem_r - 1'b1;
        pos_nxt            = pos_r + 1'b1;
      end else if (q_rd.valid) begin
        q_pop        = 1'b1;
        out_nxt      = q_rd.op.item;
        out_nxt.last = q_rd.op.item.last && (q_rd.op.rep == '0);
        ov_nxt       = 1'b1;
        rem_nxt      = q_rd.op.rep;
        pos_nxt      = q_rd.op.item.position;
        attr_nxt     = q_rd.op.item.attribute;
        lst_nxt      = q_rd.op.item.last;
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      rem_r <= '0;
    end else begin
      ov_r   <= ov_nxt;
      out_r  <= out_nxt;
      rem_r  <= rem_nxt;
      pos_r  <= pos_nxt;
      attr_r <= attr_nxt;
      lst_r  <= lst_nxt;
    end
  end

endmodule

// ===== hdl/utf8_line_to_attributed_chars_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_line_to_attributed_chars_core: UTF-8 line decoder with tab expansion
// Turns the bytes of one text line into positioned display characters.
// ----------------------------------------------------------------------------
// The front sequencer takes one byte at a time and steps through one state
// per action (backspace, held bytes, the byte itself, line end, hand-off),
// and waits while the queue is full, so the byte rate is set by that state
// machine. Words go through a short queue to the result stage, which gives
// one word per cycle while out_stall is low; a tab becomes one queue entry
// that the result stage expands into up to 16 spaces, one per cycle while
// out_stall is low. A tab_width write makes the front rebuild the column
// phase, during which in_stall is high.
module utf8_line_to_attributed_chars_core import ulac_pkg::*; #(
  parameter int LINE_CHARS  = ULAC_LINE_CHARS,
  parameter int QUEUE_DEPTH = ULAC_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [TAB_W-1:0] cfg_wdata
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  ulac_front #(
    .LINE_CHARS(LINE_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_wr     (q_wr),
    .q_full   (q_full)
  );

  ulac_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .q_full(q_full),
    .q_pop (q_pop),
    .q_rd  (q_rd)
  );

  ulac_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rd     (q_rd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.valid |-> !q_full)
    else $error("queue written while full");

  a_line_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == KIND_END) |-> out_item.last)
    else $error("line end word not marked as last");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input taken while the tab phase is rebuilt");

endmodule

// ===== sim/ulac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulac_checker: output word predictor and comparator for the line decoder
// Watches the input channel, the output channel and the tab width port. Each
// accepted input word runs through a decoder model kept here, which queues the
// output words it should cause. Each accepted output word is compared field by
// field with the oldest queued word.
// ----------------------------------------------------------------------------
module ulac_checker import ulac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [TAB_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               words_due
);

  localparam int                LINE_LEN    = ULAC_LINE_CHARS;
  localparam logic [CODE_W-1:0] SUBST_UPPER = 16'h0350;
  localparam logic [CODE_W-1:0] SUBST_LOWER = 16'h0060;

  out_item_t         chars_due[$];
  logic [TAB_W-1:0]  tab_stop;
  int                col;
  logic [ATTR_W-1:0] attr_now;
  logic [7:0]        lead_byte;
  logic [7:0]        mid_byte;
  int                held_cnt;
  bit                bs_pending;

  function automatic bit is_lead(input logic [7:0] b);
    return (b[7:5] == 3'b110) || (b[7:4] == 4'b1110);
  endfunction

  function automatic bit is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic void queue_word(input logic kind, input int pos,
                                     input logic [CODE_W-1:0] code,
                                     input logic [ATTR_W-1:0] attr,
                                     input logic special, input logic bold,
                                     input logic bad);
    out_item_t w;
    w.kind         = kind;
    w.position     = POS_W'(pos);
    w.code_point   = code;
    w.attribute    = attr;
    w.special_mark = special;
    w.bold         = bold;
    w.bad_byte     = bad;
    w.last         = 1'b0;
    chars_due.push_back(w);
  endfunction

  function automatic void place_char(input logic [CODE_W-1:0] code,
                                     input logic special, input logic bad);
    if (col < LINE_LEN) begin
      queue_word(KIND_CHAR, col, code, attr_now, special, 1'b0, bad);
      col++;
    end
  endfunction

  function automatic void place_subst(input logic [7:0] b);
    logic [CODE_W-1:0] code;
    code = CODE_W'(b) + (b[6] ? SUBST_UPPER : SUBST_LOWER);
    place_char(code, 1'b0, 1'b1);
  endfunction

  function automatic void begin_char(input logic [7:0] b);
    int stop;
    if (col >= LINE_LEN) begin
      return;
    end
    if (is_lead(b)) begin
      lead_byte = b;
      held_cnt  = 1;
    end else if (b == B_CR) begin
      place_char(CODE_W'(CH_SEMI), 1'b1, 1'b0);
    end else if (b == B_TAB) begin
      stop = (tab_stop == '0) ? 1 : ((tab_stop > TAB_MAX) ? int'(TAB_MAX) : int'(tab_stop));
      place_char(CODE_W'(CH_SPACE), 1'b1, 1'b0);
      while ((col % stop) != 0 && col < LINE_LEN) begin
        place_char(CODE_W'(CH_SPACE), 1'b0, 1'b0);
      end
    end else if (b == B_BS) begin
      if (col > 0) begin
        bs_pending = 1'b1;
      end
    end else if (b[7]) begin
      place_subst(b);
    end else if (b < B_CTRL_TOP) begin
      place_char(CODE_W'(b + CTRL_OFFSET), 1'b1, 1'b0);
    end else begin
      place_char(CODE_W'(b), 1'b0, 1'b0);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (bs_pending) begin
      bs_pending = 1'b0;
      if (b > CH_SPACE && b <= CH_TILDE) begin
        queue_word(KIND_CHAR, col - 1, CODE_W'(b), '0, 1'b0, 1'b1, 1'b0);
        return;
      end
      col--;
    end
    if (held_cnt == 1) begin
      held_cnt = 0;
      if (is_cont(b)) begin
        if (lead_byte == B_ATTR_LEAD) begin
          attr_now = b[ATTR_W-1:0];
          return;
        end
        if (lead_byte[7:5] == 3'b110) begin
          place_char(CODE_W'({lead_byte[4:0], b[5:0]}), 1'b0, 1'b0);
          return;
        end
        mid_byte = b;
        held_cnt = 2;
        return;
      end
      place_subst(lead_byte);
    end else if (held_cnt == 2) begin
      held_cnt = 0;
      if (is_cont(b)) begin
        place_char({lead_byte[3:0], mid_byte[5:0], b[5:0]}, 1'b0, 1'b0);
        return;
      end
      place_subst(lead_byte);
      place_subst(mid_byte);
    end
    begin_char(b);
  endfunction

  function automatic void close_line();
    if (bs_pending) begin
      bs_pending = 1'b0;
      col--;
    end
    if (held_cnt >= 1) begin
      place_subst(lead_byte);
    end
    if (held_cnt == 2) begin
      place_subst(mid_byte);
    end
    held_cnt = 0;
    queue_word(KIND_END, col, '0, '0, 1'b0, 1'b0, 1'b0);
    col      = 0;
    attr_now = '0;
  endfunction

  function automatic void predict_word(input in_item_t w);
    int        first;
    out_item_t tail;
    first = chars_due.size();
    decode_byte(w.byte_in);
    if (w.line_end) begin
      close_line();
    end
    if (chars_due.size() > first) begin
      tail      = chars_due.pop_back();
      tail.last = 1'b1;
      chars_due.push_back(tail);
    end
  endfunction

  function automatic void check_field(input string name, input int exp, input int got);
    if (exp != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t due;
    if (!rst_n) begin
      chars_due.delete();
      tab_stop   = TAB_RESET;
      col        = 0;
      attr_now   = '0;
      lead_byte  = '0;
      mid_byte   = '0;
      held_cnt   = 0;
      bs_pending = 1'b0;
    end else begin
      if (cfg_we) begin
        tab_stop = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (chars_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %0d position %0d code 0x%0h",
                   $time, out_item.kind, out_item.position, out_item.code_point);
          fail_count++;
        end else begin
          due = chars_due.pop_front();
          check_field("kind", due.kind, out_item.kind);
          check_field("position", due.position, out_item.position);
          check_field("code_point", due.code_point, out_item.code_point);
          check_field("attribute", due.attribute, out_item.attribute);
          check_field("special_mark", due.special_mark, out_item.special_mark);
          check_field("bold", due.bold, out_item.bold);
          check_field("bad_byte", due.bad_byte, out_item.bad_byte);
          check_field("last", due.last, out_item.last);
        end
      end
      if (in_valid && !in_stall) begin
        predict_word(in_item);
      end
    end
    words_due = chars_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the line character decoder
// Resets the block, sets several tab widths, and sends two directed lines, full
// lines and random lines built mostly from well-formed UTF-8, markers, tabs
// and overstrikes, with random gaps and stalls on both channels and one long
// output stall. The checker predicts and compares the output words.
// ----------------------------------------------------------------------------
module tb_top;
  import ulac_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 150;

  typedef enum int {IDLE_NONE, IDLE_RANDOM, IDLE_SPARSE} idle_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_we    = 1'b0;
  logic [TAB_W-1:0] cfg_wdata = '0;

  int         fail_count;
  int         words_due;
  int         cycles     = 0;
  int         items_sent = 0;
  int         rx_words   = 0;
  bit         hold_done  = 1'b0;
  idle_t      idle_mode  = IDLE_RANDOM;
  logic [7:0] line_bytes[$];

  always #6 clk = ~clk;

  utf8_line_to_attributed_chars_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ulac_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** utf8_line_to_attributed_chars_core: FAILED **");
      $finish;
    end
  end

  function automatic int draw_gap();
    case (idle_mode)
      IDLE_NONE: return 0;
      IDLE_RANDOM: return $urandom_range(0, 13);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{byte_in: b, line_end: e};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_line(input bit allow_cut);
    int cut;
    cut = line_bytes.size() - 1;
    if (allow_cut && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, line_bytes.size() - 1);
    end
    foreach (line_bytes[i]) begin
      send_byte(line_bytes[i], i == cut || i == line_bytes.size() - 1);
    end
  endtask

  task automatic build_flood();
    line_bytes.delete();
    repeat (20) line_bytes.push_back(B_TAB);
    line_bytes.push_back(8'h51);
    line_bytes.push_back(8'hC3);
    line_bytes.push_back(B_BS);
    line_bytes.push_back(8'hE9);
  endtask

  task automatic build_line(input int tokens);
    logic [7:0] lead;
    line_bytes.delete();
    repeat (tokens) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        6: line_bytes.push_back(8'($urandom_range(0, 31)));
        7, 19: line_bytes.push_back(B_TAB);
        8: line_bytes.push_back(B_CR);
        9, 10: begin
          line_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          line_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        11, 12: begin
          line_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          line_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          line_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        13: begin
          line_bytes.push_back(B_ATTR_LEAD);
          line_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        14, 15: begin
          line_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
          line_bytes.push_back(B_BS);
          if ($urandom_range(0, 3) != 0) begin
            line_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
          end else begin
            line_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        16: line_bytes.push_back(B_BS);
        17: line_bytes.push_back(8'($urandom_range(0, 255)));
        default: begin
          lead = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'hC0, 8'hDF))
                                             : 8'($urandom_range(8'hE0, 8'hEF));
          line_bytes.push_back(lead);
          if (lead[5] && $urandom_range(0, 1) == 0) begin
            line_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          end
          if ($urandom_range(0, 1) == 0) begin
            line_bytes.push_back(8'($urandom_range(0, 8'h7F)));
          end else begin
            line_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
          end
        end
      endcase
    end
  endtask

  task automatic random_phase(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      build_line($urandom_range(1, 24));
      send_line(1'b1);
    end
  endtask

  task automatic set_tab_width(input logic [TAB_W-1:0] w);
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : rx_side
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (!hold_done && rx_words >= HOLD_AFTER) begin
        gap       = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      rx_words++;
      @(negedge clk);
    end
  end

  initial begin : stim
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    set_tab_width(5'd16);
    line_bytes = '{8'h41, 8'h00, 8'h1F, B_CR, B_TAB, B_ATTR_LEAD, 8'h95, 8'hC3, 8'hA9,
                   8'hEF, 8'hBF, 8'hBF, 8'h78, B_BS, 8'h79, 8'h7A, B_BS, CH_SPACE,
                   8'h80, 8'hFF, 8'hC3, 8'h61, 8'hE2, 8'h82, 8'h62, 8'hE2};
    send_line(1'b0);
    line_bytes = '{B_BS, 8'h71, B_BS};
    send_line(1'b0);

    idle_mode = IDLE_NONE;
    build_flood();
    send_line(1'b0);
    random_phase(25);

    set_tab_width(5'd1);
    idle_mode = IDLE_RANDOM;
    random_phase(25);

    set_tab_width(5'd5);
    idle_mode = IDLE_SPARSE;
    random_phase(25);

    set_tab_width(5'd14);
    idle_mode = IDLE_RANDOM;
    build_flood();
    send_line(1'b0);
    random_phase(25);

    set_tab_width(5'd8);
    idle_mode = IDLE_NONE;
    random_phase(25);

    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("** utf8_line_to_attributed_chars_core: PASSED **");
    end else begin
      $display("** utf8_line_to_attributed_chars_core: FAILED **");
    end
    $finish;
  end

endmodule
